/* design/fhr_pkg.sv */
// Shared types and constants for the fragment hole reassembly block.
// Used by fhr_cell, fhr_chain and fragment_hole_reassembly; no dependencies.
`default_nettype none
package fhr_pkg;

	localparam int MAX_HOLES = 16;
	localparam logic [32:0] HDR_BYTES = 33'd28;
	localparam logic [63:0] MAGIC_VALUE = 64'h3154415453534355;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_OLD      = 3'd1,
		ST_BADLEN   = 3'd2,
		ST_BADMAGIC = 3'd3,
		ST_NOHOLE   = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_SET_START,
		OP_SET_END,
		OP_DELETE,
		OP_SPLIT
	} op_t;

	typedef struct packed {
		logic        tok;
		logic        hit_found;
		logic        spare_found;
		logic        left;
		logic        right;
		logic [31:0] hit_end;
		logic [1:0]  vcount;
	} probe_t;

	typedef struct packed {
		logic        clr;
		op_t         op;
		logic [31:0] foff;
		logic [32:0] fend;
		logic [31:0] split_end;
		logic [31:0] msize;
	} cmd_t;

endpackage
`default_nettype wire

/* design/fhr_cell.sv */
// One hole table entry with its stage of the search token path.
// Depends on fhr_pkg.
`default_nettype none
module fhr_cell (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            head,
	input  wire fhr_pkg::cmd_t   cmd,
	input  wire fhr_pkg::probe_t probe_in,
	output fhr_pkg::probe_t      probe_out
);
	import fhr_pkg::*;

	logic [31:0] start_q;
	logic [31:0] end_q;
	logic        inv_q;
	logic        hit_mark_q;
	logic        spare_mark_q;
	probe_t      probe_q;
	logic        valid;
	logic        fits;
	logic        spare;
	probe_t      probe_d;

	assign valid = inv_q ^ head;
	assign fits = valid && !probe_in.hit_found && ({1'b0, cmd.foff} >= {1'b0, start_q})
		&& (cmd.fend <= {1'b0, end_q});
	assign spare = !valid && !probe_in.spare_found;

	always_comb begin
		probe_d = probe_in;
		probe_d.hit_found = probe_in.hit_found | fits;
		probe_d.spare_found = probe_in.spare_found | spare;
		if (valid && probe_in.vcount != 2'd2) begin
			probe_d.vcount = probe_in.vcount + 2'd1;
		end
		if (fits) begin
			probe_d.left = cmd.foff > start_q;
			probe_d.right = cmd.fend < {1'b0, end_q};
			probe_d.hit_end = end_q;
		end
	end

	// advance the token one cell per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			probe_q <= '0;
		end else begin
			probe_q <= probe_d;
		end
	end

	always_ff @(posedge clk) begin
		if (probe_in.tok) begin
			hit_mark_q <= fits;
			spare_mark_q <= spare;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			end_q <= '0;
			inv_q <= 1'b0;
		end else if (cmd.clr) begin
			start_q <= '0;
			end_q <= head ? cmd.msize : 32'd0;
			inv_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_SET_START: begin
					if (hit_mark_q) start_q <= cmd.fend[31:0];
				end
				OP_SET_END: begin
					if (hit_mark_q) end_q <= cmd.foff;
				end
				OP_DELETE: begin
					if (hit_mark_q) inv_q <= head;
				end
				OP_SPLIT: begin
					if (hit_mark_q) begin
						end_q <= cmd.foff;
					end else if (spare_mark_q) begin
						start_q <= cmd.fend[31:0];
						end_q <= cmd.split_end;
						inv_q <= ~head;
					end
				end
				default: begin
				end
			endcase
		end
	end

	assign probe_out = probe_q;

endmodule
`default_nettype wire

/* design/fhr_chain.sv */
// Row of MAX_HOLES hole cells linked by the search token path.
// Depends on fhr_pkg and fhr_cell.
`default_nettype none
module fhr_chain (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire fhr_pkg::cmd_t   cmd,
	input  wire fhr_pkg::probe_t probe_in,
	output fhr_pkg::probe_t      probe_out
);
	import fhr_pkg::*;

	probe_t link [MAX_HOLES+1];

	assign link[0] = probe_in;

	for (genvar i = 0; i < MAX_HOLES; i++) begin : g_cell
		fhr_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.head      (i == 0),
			.cmd       (cmd),
			.probe_in  (link[i]),
			.probe_out (link[i+1])
		);
	end

	assign probe_out = link[MAX_HOLES];

endmodule
`default_nettype wire

/* design/fragment_hole_reassembly.sv */
// Top level of the fragment hole reassembly tracker: header checks, control, output register.
// Depends on fhr_pkg and fhr_chain.
//
// One fragment header enters per item and gives exactly one result item. A header that fails
// the length or magic check, or carries an older timestamp, goes from the check state
// straight to the done state. Otherwise a search token walks the row of MAX_HOLES hole cells
// one cell per cycle; a header that starts a newer message first clears the row. The input
// stalls until the result is loaded into the output register; a waiting result does not block
// the next item from being taken.
`default_nettype none
module fragment_hole_reassembly (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [63:0] magic_word,
	input  wire logic [63:0] message_timestamp,
	input  wire logic [31:0] message_size,
	input  wire logic [31:0] fragment_offset,
	input  wire logic [31:0] fragment_size,
	input  wire logic [10:0] packet_length,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic             message_complete,
	output logic             size_mismatch,
	output logic             new_message,
	output logic [31:0]      received_count
);
	import fhr_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_CLEAR,
		S_INJECT,
		S_SCAN,
		S_APPLY,
		S_DONE
	} state_t;

	state_t      state_q;
	logic [63:0] stamp_q;
	logic [31:0] msize_q;
	logic [31:0] foff_q;
	logic [32:0] fend_q;
	logic        badlen_q;
	logic        badmagic_q;
	logic [63:0] cur_stamp_q;
	logic [31:0] exp_size_q;
	logic [31:0] count_q;
	status_t     status_q;
	logic        complete_q;
	logic        mismatch_q;
	logic        newmsg_q;
	probe_t      scan_q;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic        out_complete_q;
	logic        out_mismatch_q;
	logic        out_newmsg_q;
	logic [31:0] out_count_q;

	logic        accept;
	logic        out_room;
	logic [32:0] fend_in;
	cmd_t        cmd;
	probe_t      inject;
	probe_t      chain_out;
	op_t         op;
	status_t     apply_status;

	assign accept = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign out_room = !out_valid_q || !out_stall;
	assign fend_in = {1'b0, fragment_offset} + {1'b0, fragment_size};

	always_comb begin
		op = OP_NONE;
		apply_status = ST_OK;
		if (!scan_q.hit_found) begin
			apply_status = ST_NOHOLE;
		end else if (scan_q.left && scan_q.right) begin
			if (scan_q.spare_found) begin
				op = OP_SPLIT;
			end else begin
				apply_status = ST_FULL;
			end
		end else if (scan_q.right) begin
			op = OP_SET_START;
		end else if (scan_q.left) begin
			op = OP_SET_END;
		end else begin
			op = OP_DELETE;
		end
	end

	always_comb begin
		cmd.clr = state_q == S_CLEAR;
		cmd.op = (state_q == S_APPLY) ? op : OP_NONE;
		cmd.foff = foff_q;
		cmd.fend = fend_q;
		cmd.split_end = scan_q.hit_end;
		cmd.msize = exp_size_q;
		inject = '0;
		inject.tok = state_q == S_INJECT;
	end

	fhr_chain u_chain (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.probe_in  (inject),
		.probe_out (chain_out)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			stamp_q <= message_timestamp;
			msize_q <= message_size;
			foff_q <= fragment_offset;
			fend_q <= fend_in;
			badlen_q <= {22'd0, packet_length} != ({1'b0, fragment_size} + HDR_BYTES);
			badmagic_q <= magic_word != MAGIC_VALUE;
		end
		if (state_q == S_SCAN && chain_out.tok) begin
			scan_q <= chain_out;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cur_stamp_q <= '0;
			exp_size_q <= '0;
			count_q <= '0;
			status_q <= ST_OK;
			complete_q <= 1'b0;
			mismatch_q <= 1'b0;
			newmsg_q <= 1'b0;
			out_valid_q <= 1'b0;
			out_status_q <= '0;
			out_complete_q <= 1'b0;
			out_mismatch_q <= 1'b0;
			out_newmsg_q <= 1'b0;
			out_count_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						status_q <= ST_OK;
						complete_q <= 1'b0;
						mismatch_q <= 1'b0;
						newmsg_q <= 1'b0;
						state_q <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (badlen_q) begin
						status_q <= ST_BADLEN;
						state_q <= S_DONE;
					end else if (badmagic_q) begin
						status_q <= ST_BADMAGIC;
						state_q <= S_DONE;
					end else begin
						count_q <= count_q + 32'd1;
						if (stamp_q < cur_stamp_q) begin
							status_q <= ST_OLD;
							state_q <= S_DONE;
						end else if (stamp_q > cur_stamp_q) begin
							cur_stamp_q <= stamp_q;
							exp_size_q <= msize_q;
							newmsg_q <= 1'b1;
							state_q <= S_CLEAR;
						end else begin
							mismatch_q <= exp_size_q != msize_q;
							state_q <= S_INJECT;
						end
					end
				end
				S_CLEAR: begin
					state_q <= S_INJECT;
				end
				S_INJECT: begin
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (chain_out.tok) state_q <= S_APPLY;
				end
				S_APPLY: begin
					status_q <= apply_status;
					complete_q <= (op == OP_DELETE) && (scan_q.vcount == 2'd1);
					state_q <= S_DONE;
				end
				S_DONE: begin
					// hold until the output register is free
					if (out_room) begin
						out_valid_q <= 1'b1;
						out_status_q <= status_q;
						out_complete_q <= complete_q;
						out_mismatch_q <= mismatch_q;
						out_newmsg_q <= newmsg_q;
						out_count_q <= count_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign message_complete = out_complete_q;
	assign size_mismatch = out_mismatch_q;
	assign new_message = out_newmsg_q;
	assign received_count = out_count_q;

	a_complete_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(message_complete && status != ST_OK))
		else $error("completion reported with a failing status");

	a_flags_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(new_message && size_mismatch))
		else $error("new message and size mismatch together");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		chain_out.tok |-> state_q == S_SCAN)
		else $error("search token left the cell row outside a scan");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && !badlen_q && !badmagic_q) |=>
		count_q == $past(count_q) + 32'd1)
		else $error("valid header not counted");

endmodule
`default_nettype wire

/* tb/fragment_hole_reassembly_tb.sv */
// Self-checking testbench for fragment_hole_reassembly: directed header table, then random
// messages with noise, under sender/receiver idling and one long receiver hold-off.
// Depends on fhr_pkg and the fragment_hole_reassembly RTL.
module fragment_hole_reassembly_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import fhr_pkg::*;

	localparam int IDLE_LIMIT = 4000;
	localparam int RANDOM_ITEMS = 920;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 40;

	typedef struct packed {
		logic [63:0] magic;
		logic [63:0] stamp;
		logic [31:0] msize;
		logic [31:0] foff;
		logic [31:0] fsize;
		logic [10:0] plen;
	} frag_hdr_t;

	typedef struct packed {
		status_t     st;
		logic        done;
		logic        mism;
		logic        fresh;
		logic [31:0] count;
	} reasm_result_t;

	typedef struct packed {
		frag_hdr_t     hdr;
		logic          typed;
		reasm_result_t want;
	} plan_row_t;

	typedef enum int {
		NZ_LENGTH,
		NZ_FSIZE,
		NZ_MAGIC_RANDOM,
		NZ_MAGIC_BIT,
		NZ_OLD_STAMP,
		NZ_SIZE
	} noise_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [63:0] magic_word = '0;
	logic [63:0] message_timestamp = '0;
	logic [31:0] message_size = '0;
	logic [31:0] fragment_offset = '0;
	logic [31:0] fragment_size = '0;
	logic [10:0] packet_length = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [2:0]  status;
	logic        message_complete;
	logic        size_mismatch;
	logic        new_message;
	logic [31:0] received_count;

	// tracker copy of the block state
	logic [63:0] cur_stamp = '0;
	logic [31:0] cur_size = '0;
	logic [31:0] good_count = '0;
	logic [31:0] gap_lo [MAX_HOLES];
	logic [31:0] gap_hi [MAX_HOLES];
	logic        gap_used [MAX_HOLES];

	reasm_result_t pending_results [$];
	int            mismatches = 0;
	int            offered = 0;
	int            send_idle = 0;
	int            recv_idle = 0;
	int            hold_left = 0;
	logic [63:0]   stamp_now = '0;

	plan_row_t directed [21] = '{
		'{'{MAGIC_VALUE, 64'd0, 32'd0, 32'd0, 32'd5, 11'd0}, 1'b1,
			'{ST_BADLEN, 1'b0, 1'b0, 1'b0, 32'd0}},
		'{'{64'hFFFF_FFFF_FFFF_FFFF, 64'd0, 32'd0, 32'd0, 32'd0, 11'd28}, 1'b1,
			'{ST_BADMAGIC, 1'b0, 1'b0, 1'b0, 32'd0}},
		'{'{MAGIC_VALUE, 64'd0, 32'd0, 32'd0, 32'd0, 11'd28}, 1'b1,
			'{ST_OK, 1'b1, 1'b0, 1'b0, 32'd1}},
		'{'{MAGIC_VALUE, 64'd0, 32'd0, 32'd0, 32'd0, 11'd28}, 1'b1,
			'{ST_NOHOLE, 1'b0, 1'b0, 1'b0, 32'd2}},
		'{'{MAGIC_VALUE, 64'd0, 32'd5, 32'd0, 32'd0, 11'd28}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd0, 32'd0, 32'd0, 32'hFFFF_FFE4, 11'd0}, 1'b1,
			'{ST_BADLEN, 1'b0, 1'b0, 1'b0, 32'd3}},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd1000, 32'd1372, 11'd1400}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd900, 32'd200, 11'd228}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd50, 32'd4000, 32'd0, 32'd0, 11'd28}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd0, 32'd500, 11'd528}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd800, 32'd200, 11'd228}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd500, 32'd300, 11'd328}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4001, 32'd2372, 32'd1000, 11'd1028}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd3372, 32'd628, 11'd656}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'd100, 32'd4000, 32'd0, 32'd0, 11'd28}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd1,
			11'd29}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFE, 32'd1,
			11'd29}, 1'b0, '0},
		'{'{MAGIC_VALUE, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'd0, 32'd0, 11'd28},
			1'b0, '0},
		'{'{MAGIC_VALUE, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'd1000, 32'd0, 11'd28},
			1'b0, '0},
		'{'{MAGIC_VALUE ^ 64'hFF, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'd2000, 32'd0,
			11'd28}, 1'b0, '0},
		'{'{64'd0, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 32'd2000, 32'd1372, 11'd1400},
			1'b0, '0}
	};

	fragment_hole_reassembly DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.magic_word(magic_word),
		.message_timestamp(message_timestamp),
		.message_size(message_size),
		.fragment_offset(fragment_offset),
		.fragment_size(fragment_size),
		.packet_length(packet_length),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.status(status),
		.message_complete(message_complete),
		.size_mismatch(size_mismatch),
		.new_message(new_message),
		.received_count(received_count)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	function automatic void reset_holes(input logic [31:0] size);
		for (int i = 0; i < MAX_HOLES; i++) begin
			gap_lo[i] = '0;
			gap_hi[i] = '0;
			gap_used[i] = 1'b0;
		end
		gap_hi[0] = size;
		gap_used[0] = 1'b1;
	endfunction

	function automatic reasm_result_t track_fragment(input frag_hdr_t h);
		reasm_result_t r;
		logic [32:0]   fend;
		logic          left;
		logic          right;
		int            hit;
		int            spare;
		r = '0;
		r.st = ST_OK;
		hit = -1;
		spare = -1;
		fend = {1'b0, h.foff} + {1'b0, h.fsize};
		if ({22'd0, h.plen} != {1'b0, h.fsize} + HDR_BYTES) begin
			r.st = ST_BADLEN;
		end else if (h.magic != MAGIC_VALUE) begin
			r.st = ST_BADMAGIC;
		end else begin
			good_count = good_count + 32'd1;
			if (h.stamp < cur_stamp) begin
				r.st = ST_OLD;
			end else begin
				if (h.stamp > cur_stamp) begin
					cur_stamp = h.stamp;
					cur_size = h.msize;
					reset_holes(h.msize);
					r.fresh = 1'b1;
				end else if (cur_size != h.msize) begin
					r.mism = 1'b1;
				end
				for (int i = 0; i < MAX_HOLES; i++) begin
					if (gap_used[i] && hit < 0 && h.foff >= gap_lo[i] &&
							fend <= {1'b0, gap_hi[i]})
						hit = i;
					if (!gap_used[i] && spare < 0)
						spare = i;
				end
				if (hit < 0) begin
					r.st = ST_NOHOLE;
				end else begin
					left = h.foff > gap_lo[hit];
					right = fend < {1'b0, gap_hi[hit]};
					if (left && right) begin
						if (spare < 0) begin
							r.st = ST_FULL;
						end else begin
							gap_lo[spare] = fend[31:0];
							gap_hi[spare] = gap_hi[hit];
							gap_used[spare] = 1'b1;
							gap_hi[hit] = h.foff;
						end
					end else if (right) begin
						gap_lo[hit] = fend[31:0];
					end else if (left) begin
						gap_hi[hit] = h.foff;
					end else begin
						gap_used[hit] = 1'b0;
					end
					if (r.st == ST_OK) begin
						r.done = 1'b1;
						for (int i = 0; i < MAX_HOLES; i++)
							if (gap_used[i])
								r.done = 1'b0;
					end
				end
			end
		end
		r.count = good_count;
		return r;
	endfunction

	task automatic offer_fragment(input frag_hdr_t h, input logic typed,
			input reasm_result_t want);
		reasm_result_t got;
		while ($urandom_range(0, 99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		magic_word <= h.magic;
		message_timestamp <= h.stamp;
		message_size <= h.msize;
		fragment_offset <= h.foff;
		fragment_size <= h.fsize;
		packet_length <= h.plen;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		got = track_fragment(h);
		pending_results.push_back(typed ? want : got);
		offered++;
		@(negedge clk);
	endtask

	task automatic run_message(input logic [63:0] step);
		logic [31:0] size;
		logic [31:0] len;
		logic [31:0] off;
		logic [31:0] offs [$];
		logic [31:0] lens [$];
		frag_hdr_t   h;
		frag_hdr_t   noisy;
		int          pick;
		int          j;
		int          k;
		stamp_now = stamp_now + step;
		pick = $urandom_range(0, 99);
		if (pick < 8) begin
			size = '0;
			offs.push_back('0);
			lens.push_back('0);
		end else if (pick < 22) begin
			// scattered fragments of zero or one byte: splits until the table overflows
			size = $urandom_range(40, 400);
			repeat (24) begin
				offs.push_back($urandom_range(1, size - 2));
				lens.push_back($urandom_range(0, 1));
			end
		end else if (pick < 30) begin
			size = $urandom() | 32'h8000_0000;
			repeat (6) begin
				offs.push_back($urandom());
				lens.push_back($urandom_range(0, 1372));
			end
		end else begin
			size = $urandom_range(1, 6000);
			off = '0;
			while (off < size) begin
				len = $urandom_range(1, 1372);
				if (len > size - off)
					len = size - off;
				offs.push_back(off);
				lens.push_back(len);
				off = off + len;
			end
			for (j = offs.size() - 1; j > 0; j--) begin
				k = $urandom_range(0, j);
				off = offs[j];
				offs[j] = offs[k];
				offs[k] = off;
				len = lens[j];
				lens[j] = lens[k];
				lens[k] = len;
			end
			if (offs.size() > 1 && $urandom_range(0, 9) == 0) begin
				void'(offs.pop_back());
				void'(lens.pop_back());
			end
		end
		for (j = 0; j < offs.size(); j++) begin
			h = '{MAGIC_VALUE, stamp_now, size, offs[j], lens[j], 11'(lens[j] + 32'd28)};
			if ($urandom_range(0, 99) < 12) begin
				noisy = h;
				case (noise_t'($urandom_range(0, 5)))
					NZ_LENGTH: noisy.plen = 11'($urandom_range(0, 1400));
					NZ_FSIZE: noisy.fsize = $urandom();
					NZ_MAGIC_RANDOM: noisy.magic = {$urandom(), $urandom()};
					NZ_MAGIC_BIT: noisy.magic = h.magic ^ (64'd1 << $urandom_range(0, 63));
					NZ_OLD_STAMP: noisy.stamp = {$urandom(), $urandom()} % stamp_now;
					default: noisy.msize = $urandom();
				endcase
				offer_fragment(noisy, 1'b0, '0);
			end
			offer_fragment(h, 1'b0, '0);
			if ($urandom_range(0, 99) < 4)
				offer_fragment(h, 1'b0, '0);
		end
	endtask

	initial begin : receiver
		forever begin
			@(negedge clk);
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(0, 99) < recv_idle);
			end
		end
	end

	always @(posedge clk) begin : result_check
		reasm_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$display("%0t: unexpected result: status %0d count %0d", $time, status,
					received_count);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.st) begin
					$display("%0t: status expected %0d actual %0d", $time, want.st, status);
					mismatches++;
				end
				if (message_complete !== want.done) begin
					$display("%0t: message_complete expected %0b actual %0b", $time,
						want.done, message_complete);
					mismatches++;
				end
				if (size_mismatch !== want.mism) begin
					$display("%0t: size_mismatch expected %0b actual %0b", $time,
						want.mism, size_mismatch);
					mismatches++;
				end
				if (new_message !== want.fresh) begin
					$display("%0t: new_message expected %0b actual %0b", $time,
						want.fresh, new_message);
					mismatches++;
				end
				if (received_count !== want.count) begin
					$display("%0t: received_count expected %0d actual %0d", $time,
						want.count, received_count);
					mismatches++;
				end
			end
		end
	end

	initial begin : watchdog
		int stuck;
		stuck = 0;
		while (stuck < IDLE_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stuck = 0;
			else
				stuck++;
		end
		$display("** fragment_hole_reassembly: FAILED **");
		$finish;
	end

	initial begin : stimulus
		int first;
		int phase;
		bit pressured;
		pressured = 1'b0;
		reset_holes('0);
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle = 16;
		recv_idle = 70;
		@(negedge clk);
		foreach (directed[n])
			offer_fragment(directed[n].hdr, directed[n].typed, directed[n].want);
		stamp_now = 64'h8000_0000_0000_0000;
		first = offered;
		while (offered - first < RANDOM_ITEMS) begin
			phase = (offered - first) * 3 / RANDOM_ITEMS;
			if (phase == 1) begin
				send_idle = 70;
				recv_idle = 16;
			end else if (phase >= 2 && !pressured) begin
				send_idle = 0;
				recv_idle = 0;
				hold_left = HOLD_CYCLES;
				pressured = 1'b1;
			end
			run_message($urandom_range(1, 1000));
		end
		stamp_now = 64'hFFFF_FFFF_FFFF_FFFE;
		run_message(64'd1);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("** fragment_hole_reassembly: PASSED **");
		else
			$display("** fragment_hole_reassembly: FAILED **");
		$finish;
	end

endmodule

/* filelist.f */
design/fhr_pkg.sv
design/fhr_cell.sv
design/fhr_chain.sv
design/fragment_hole_reassembly.sv
tb/fragment_hole_reassembly_tb.sv
